### design/wddf_pkg.sv
package wddf_pkg;

	// Q16.16 coordinate and the one-bit-wider difference of two coordinates
	typedef logic signed [31:0] coord_t;
	typedef logic signed [32:0] diff_t;

	// squared threshold, Q30.32 of an unsigned 31-bit value
	typedef logic [61:0] thr_sq_t;

	// kept-point count of the current path, saturating at two
	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_TWO  = 2'd2;

	// path tracking state: newest kept point and the heading that led to it
	typedef struct packed {
		logic [1:0] seen;
		coord_t     newest_x;
		coord_t     newest_y;
		diff_t      head_x;
		diff_t      head_y;
	} track_t;

	// decision for one waypoint and the state that follows it
	typedef struct packed {
		logic   keep;
		track_t next;
	} eval_t;

endpackage

### design/wddf_cfg.sv
module wddf_cfg import wddf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata,
	output thr_sq_t     thr_sq
);

	thr_sq_t thr_sq_q;

	// square the threshold once at write time so the datapath only compares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q <= '0;
		end else if (cfg_we) begin
			thr_sq_q <= thr_sq_t'(cfg_wdata) * thr_sq_t'(cfg_wdata);
		end
	end

	assign thr_sq = thr_sq_q;

endmodule

### design/wddf_eval.sv
module wddf_eval import wddf_pkg::*; (
	input  logic    first,
	input  coord_t  x,
	input  coord_t  y,
	input  track_t  track,
	input  thr_sq_t thr_sq,
	output eval_t   ev
);

	diff_t              cx;
	diff_t              cy;
	logic signed [65:0] dot_x;
	logic signed [65:0] dot_y;
	logic signed [66:0] dot;
	logic signed [65:0] sq_x;
	logic signed [65:0] sq_y;
	logic        [65:0] d2;
	logic               dot_pos;
	logic               far;

	// candidate heading from the newest kept point
	assign cx = diff_t'(x) - diff_t'(track.newest_x);
	assign cy = diff_t'(y) - diff_t'(track.newest_y);

	// heading agreement: dot product strictly positive
	assign dot_x   = track.head_x * cx;
	assign dot_y   = track.head_y * cy;
	assign dot     = {dot_x[65], dot_x} + {dot_y[65], dot_y};
	assign dot_pos = !dot[66] && (dot != '0);

	// step length: squared planar distance strictly above squared threshold
	assign sq_x = cx * cx;
	assign sq_y = cy * cy;
	assign d2   = $unsigned(sq_x) + $unsigned(sq_y);
	assign far  = d2 > {4'b0000, thr_sq};

	// decision and next tracking state
	always_comb begin
		ev.keep = 1'b0;
		ev.next = track;
		priority if (first || track.seen == SEEN_NONE) begin
			ev.keep          = 1'b1;
			ev.next.seen     = SEEN_ONE;
			ev.next.newest_x = x;
			ev.next.newest_y = y;
		end else if (track.seen == SEEN_ONE) begin
			// second point always passes and sets the first heading
			ev.keep          = 1'b1;
			ev.next.seen     = SEEN_TWO;
			ev.next.newest_x = x;
			ev.next.newest_y = y;
			ev.next.head_x   = cx;
			ev.next.head_y   = cy;
		end else begin
			ev.keep = dot_pos && far;
			if (dot_pos && far) begin
				ev.next.newest_x = x;
				ev.next.newest_y = y;
				ev.next.head_x   = cx;
				ev.next.head_y   = cy;
			end
		end
	end

endmodule

### design/waypoint_direction_distance_filter.sv
// Waypoint direction and distance filter. Accepts one waypoint per clock while
// item_stall is low and delivers each kept waypoint through the input register,
// then the result register; dropped waypoints produce no result transaction.
// The rate is set by the single evaluate stage: the candidate heading, four
// 33x33 signed products, the dot-product sign and the squared-distance
// compare all sit between the input register and the tracking state that
// the very next waypoint reads. The threshold is squared when cfg_we writes
// it, so a write takes effect for waypoints evaluated from the next cycle.
// Only x and y are examined; z passes through untouched. The first two
// points of a path always pass, and a point arriving with no path started
// opens one. When result_stall holds the output, one more waypoint is taken
// into the input register before item_stall rises.
module waypoint_direction_distance_filter import wddf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        first_of_path,
	input  coord_t      x_coord,
	input  coord_t      y_coord,
	input  coord_t      z_coord,
	output logic        result_valid,
	input  logic        result_stall,
	output coord_t      out_x,
	output coord_t      out_y,
	output coord_t      out_z,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata
);

	logic    valid_s1;
	logic    first_s1;
	coord_t  x_s1;
	coord_t  y_s1;
	coord_t  z_s1;
	logic    valid_s2;
	coord_t  x_s2;
	coord_t  y_s2;
	coord_t  z_s2;
	track_t  track_q;
	thr_sq_t thr_sq;
	eval_t   ev;
	logic    advance;
	logic    load_s1;

	// stage 1 moves on unless a result is waiting and stalled
	assign advance    = !(valid_s2 && result_stall);
	assign load_s1    = !valid_s1 || advance;
	assign item_stall = valid_s1 && !advance;

	wddf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.thr_sq    (thr_sq)
	);

	wddf_eval u_eval (
		.first  (first_s1),
		.x      (x_s1),
		.y      (y_s1),
		.track  (track_q),
		.thr_sq (thr_sq),
		.ev     (ev)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && item_valid) begin
			first_s1 <= first_of_path;
			x_s1     <= x_coord;
			y_s1     <= y_coord;
			z_s1     <= z_coord;
		end
	end

	// tracking state, updated as each waypoint leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '0;
		end else if (valid_s1 && advance) begin
			track_q <= ev.next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && ev.keep;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && ev.keep) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
		end
	end

	assign result_valid = valid_s2;
	assign out_x        = x_s2;
	assign out_y        = y_s2;
	assign out_z        = z_s2;

	// upstream is held only while stage 1 is full behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && valid_s2 && result_stall)
		else $error("item_stall without a stalled result behind it");

	// the first point of a path always produces a result
	a_first_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && first_s1 |=> valid_s2 && track_q.seen == SEEN_ONE)
		else $error("first point of path not passed");

	// once a waypoint is processed a path is always open
	a_path_open: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> track_q.seen != SEEN_NONE)
		else $error("tracking state empty after a processed waypoint");

endmodule

### tb/waypoint_direction_distance_filter_tb.sv
`timescale 1ns / 100ps

module waypoint_direction_distance_filter_tb;
	import wddf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 400;
	localparam int MAX_SHOWN      = 30;

	// one kept waypoint as it should leave the block
	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} waypoint_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        item_valid    = 1'b0;
	logic        item_stall;
	logic        first_of_path = 1'b0;
	coord_t      x_coord       = '0;
	coord_t      y_coord       = '0;
	coord_t      z_coord       = '0;
	logic        result_valid;
	logic        result_stall  = 1'b0;
	coord_t      out_x;
	coord_t      out_y;
	coord_t      out_z;
	logic        cfg_we        = 1'b0;
	logic [30:0] cfg_wdata     = '0;

	// filter state as the testbench tracks it
	logic [1:0]  pred_seen;
	coord_t      pred_older_x, pred_older_y;
	coord_t      pred_newest_x, pred_newest_y;
	logic [30:0] pred_thr;

	waypoint_t   kept_q[$];

	int errors             = 0;
	int items_sent         = 0;
	int results_seen       = 0;
	int thresholds_written = 0;
	int send_idle_pct      = 0;
	int recv_idle_pct      = 0;
	int idle_run           = 0;
	int hold_left          = 0;
	logic hold_start       = 1'b0;

	waypoint_direction_distance_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.first_of_path(first_of_path),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.z_coord      (z_coord),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	// decide keep/drop for one accepted waypoint and queue the kept one
	task automatic predict_waypoint(input logic fop, input coord_t x, input coord_t y,
			input coord_t z);
		logic signed [33:0] px, py, cx, cy;
		logic signed [69:0] dot, d2;
		logic [69:0]        t2;
		logic               keep;
		waypoint_t          wp;
		keep = 1'b0;
		if (fop || pred_seen == SEEN_NONE) begin
			pred_seen     = SEEN_ONE;
			pred_newest_x = x;
			pred_newest_y = y;
			keep          = 1'b1;
		end else if (pred_seen == SEEN_ONE) begin
			pred_seen     = SEEN_TWO;
			pred_older_x  = pred_newest_x;
			pred_older_y  = pred_newest_y;
			pred_newest_x = x;
			pred_newest_y = y;
			keep          = 1'b1;
		end else begin
			px   = 34'(pred_newest_x) - 34'(pred_older_x);
			py   = 34'(pred_newest_y) - 34'(pred_older_y);
			cx   = 34'(x) - 34'(pred_newest_x);
			cy   = 34'(y) - 34'(pred_newest_y);
			dot  = 70'(px) * 70'(cx) + 70'(py) * 70'(cy);
			d2   = 70'(cx) * 70'(cx) + 70'(cy) * 70'(cy);
			t2   = 70'(pred_thr) * 70'(pred_thr);
			keep = (dot > 0) && ($unsigned(d2) > t2);
			if (keep) begin
				pred_older_x  = pred_newest_x;
				pred_older_y  = pred_newest_y;
				pred_newest_x = x;
				pred_newest_y = y;
			end
		end
		if (keep) begin
			wp.x = x;
			wp.y = y;
			wp.z = z;
			kept_q = {kept_q, wp};
		end
	endtask

	// offer one waypoint, with optional idle cycles first; valid stays high afterwards
	task automatic send_wp(input logic fop, input coord_t x, input coord_t y, input coord_t z);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct)
				@(posedge clk);
		end
		item_valid    <= 1'b1;
		first_of_path <= fop;
		x_coord       <= x;
		y_coord       <= y;
		z_coord       <= z;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
		predict_waypoint(fop, x, y, z);
	endtask

	// stop sending and let every kept waypoint and any dropped one in flight clear
	task automatic drain_results();
		item_valid <= 1'b0;
		while (kept_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [30:0] thr);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pred_thr = thr;
		thresholds_written++;
	endtask

	// corner cases: no path started, repeated points, zero/perpendicular/reverse
	// headings, one-point paths, full-range coordinates, threshold equality
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_wp(1'b0, 32'sh0, 32'sh0, 32'sh7fffffff);
		send_wp(1'b0, 32'sh0, 32'sh0, 32'sh80000000);
		send_wp(1'b0, 32'sh10000, 32'sh0, 32'sh0);
		send_wp(1'b1, 32'sh0, 32'sh0, 32'sh0);
		send_wp(1'b0, 32'sh10000, 32'sh0, 32'sh1);
		send_wp(1'b0, 32'sh20000, 32'sh0, 32'sh2);
		send_wp(1'b0, 32'sh20000, 32'sh10000, 32'sh3);
		send_wp(1'b0, 32'sh10000, 32'sh0, 32'sh4);
		send_wp(1'b0, 32'sh20000, 32'sh0, 32'sh5);
		send_wp(1'b0, 32'sh30000, 32'sh5, 32'sh6);
		send_wp(1'b1, 32'sh5, 32'sh5, 32'sh5);
		send_wp(1'b1, -32'sh5, -32'sh5, -32'sh5);
		send_wp(1'b1, 32'sh80000000, 32'sh80000000, 32'sh0);
		send_wp(1'b0, 32'sh0, 32'sh0, 32'shffffffff);
		send_wp(1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_wp(1'b0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		// step of exactly the threshold is dropped, one lsb more passes
		set_threshold(31'h10000);
		send_wp(1'b1, 32'sh0, 32'sh0, 32'sh0);
		send_wp(1'b0, 32'sh10000, 32'sh0, 32'sh0);
		send_wp(1'b0, 32'sh20000, 32'sh0, 32'sh0);
		send_wp(1'b0, 32'sh20001, 32'sh0, 32'sh0);
		set_threshold(31'h7fffffff);
		send_wp(1'b1, 32'sh80000000, 32'sh0, 32'sh0);
		send_wp(1'b0, 32'sh0, 32'sh0, 32'sh0);
		send_wp(1'b0, 32'sh7fffffff, 32'sh0, 32'sh0);
		send_wp(1'b0, 32'sh7fffffff, 32'sh1, 32'sh0);
		set_threshold(31'h0);
	endtask

	// receiver holds off for a long stretch while a straight path keeps coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		for (int i = 0; i < 40; i++)
			send_wp(i == 0, coord_t'(i * 32'h10000), coord_t'(i * 32'h8000), coord_t'(i));
		drain_results();
	endtask

	// mostly well-formed paths with forward-biased steps sized to the threshold,
	// plus full-range paths, flag noise and paths that start without a flag
	task automatic test_random(input int send_pct, input int recv_pct,
			input logic [30:0] thr_a, input logic [30:0] thr_b, input int n);
		int                 sent;
		int                 len;
		int                 mode;
		int                 dx, dy;
		int unsigned        s;
		logic               fop;
		logic [30:0]        thr;
		logic signed [32:0] hx, hy;
		coord_t             x, y, z;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int half = 0; half < 2; half++) begin
			thr = (half == 0) ? thr_a : thr_b;
			set_threshold(thr);
			if (thr == 0)
				s = 32'h40000;
			else if (thr >= 31'h20000000)
				s = 32'h7fffffff;
			else
				s = 2 * thr + 32'h100;
			sent = 0;
			while (sent < n / 2) begin
				len  = $urandom_range(1, 12);
				mode = $urandom_range(0, 9);
				for (int i = 0; i < len; i++) begin
					z = $urandom;
					if (i == 0)
						fop = ($urandom_range(0, 9) != 0);
					else
						fop = (mode == 1) ? ($urandom_range(0, 3) == 0) : 1'b0;
					if (mode == 0 || (i == 0 && $urandom_range(0, 1))) begin
						x = $urandom;
						y = $urandom;
					end else begin
						hx = 33'(pred_newest_x) - 33'(pred_older_x);
						hy = 33'(pred_newest_y) - 33'(pred_older_y);
						dx = $urandom_range(0, s);
						dy = $urandom_range(0, s);
						if (($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : hx[32])
							dx = -dx;
						if (($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : hy[32])
							dy = -dy;
						if ($urandom_range(0, 19) == 0) begin
							dx = 0;
							dy = 0;
						end
						x = pred_newest_x + dx;
						y = pred_newest_y + dy;
					end
					send_wp(fop, x, y, z);
					sent++;
				end
			end
		end
		drain_results();
	endtask

	// receiver stall: random idling plus the long hold when requested
	always @(posedge clk) begin
		if (hold_start)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		result_stall <= hold_start || (hold_left > 1) || ($urandom_range(0, 99) < recv_idle_pct);
	end

	// compare each result transaction with the oldest kept waypoint
	always @(posedge clk) begin
		waypoint_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (kept_q.size() == 0) begin
				note_mismatch($sformatf("unexpected result %h %h %h", out_x, out_y, out_z));
			end else begin
				want = kept_q.pop_front();
				if (out_x !== want.x)
					note_mismatch($sformatf("out_x got %h want %h", out_x, want.x));
				if (out_y !== want.y)
					note_mismatch($sformatf("out_y got %h want %h", out_y, want.y));
				if (out_z !== want.z)
					note_mismatch($sformatf("out_z got %h want %h", out_z, want.z));
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_run);
			$display("FAIL waypoint_direction_distance_filter");
			$finish;
		end
	end

	initial begin
		pred_seen     = SEEN_NONE;
		pred_older_x  = '0;
		pred_older_y  = '0;
		pred_newest_x = '0;
		pred_newest_y = '0;
		pred_thr      = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random(8, 80, 31'h8000, 31'($urandom), 400);
		test_random(80, 8, 31'h40000, 31'h0, 400);
		test_random(0, 0, 31'($urandom_range(1, 32'hfffff)), 31'h7fffffff, 400);

		drain_results();
		if (kept_q.size() != 0)
			note_mismatch($sformatf("%0d kept waypoints never came out", kept_q.size()));

		$display("covered %0d waypoints, %0d kept results, %0d threshold writes",
			items_sent, results_seen, thresholds_written);
		$display("idle mixes: sender-light/receiver-heavy, the reverse, none; one long hold");
		if (errors == 0)
			$display("PASS waypoint_direction_distance_filter");
		else
			$display("FAIL waypoint_direction_distance_filter");
		$finish;
	end

endmodule
